>>> hw/rtl/vsp_pkg.sv
package vsp_pkg;

  localparam int COEF_COUNT = 20;
  localparam int DEPTH_ROW  = 16;
  localparam int COEF_WIDTH = 32;
  localparam int IDX_WIDTH  = 5;
  localparam int ROW_COUNT  = 4;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_e;

  // per-item status carried through the divider
  typedef struct packed {
    logic       sat;
    logic       zero;
    logic [3:0] neg;
  } vsp_flags_t;

endpackage

>>> hw/rtl/vsp_if.sv
interface vsp_in_if import vsp_pkg::*; #(
  parameter int COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  op_e                           operation;
  logic [IDX_WIDTH-1:0]          coef_index;
  logic signed [COEF_WIDTH-1:0]  coef_value;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic signed [COORD_WIDTH-1:0] point_w;

  modport source (
    output valid, operation, coef_index, coef_value, point_x, point_y, point_z, point_w,
    input  ready
  );
  modport sink (
    input  valid, operation, coef_index, coef_value, point_x, point_y, point_z, point_w,
    output ready
  );
endinterface

interface vsp_out_if #(
  parameter int COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] screen_x;
  logic signed [COORD_WIDTH-1:0] screen_y;
  logic signed [COORD_WIDTH-1:0] screen_z;
  logic signed [COORD_WIDTH-1:0] screen_w;
  logic                          depth_zero;
  logic                          saturated;

  modport source (
    output valid, screen_x, screen_y, screen_z, screen_w, depth_zero, saturated,
    input  ready
  );
  modport sink (
    input  valid, screen_x, screen_y, screen_z, screen_w, depth_zero, saturated,
    output ready
  );
endinterface

>>> hw/rtl/vertex_screen_projection.sv
// vertex screen projection
// pnt_i carries load and transform beats. a load beat (operation 0) writes
// coef_value into store entry coef_index: 0..15 the full matrix row-major,
// 16..19 the camera depth row; indexes 20..31 are dropped. a load gives no
// result beat and takes effect for every transform beat accepted after it.
// a transform beat (operation 1) multiplies the point by the matrix and by
// the depth row, then divides all four components by the negated depth.
// each transform gives one beat on scr_o; zero depth gives zeros with
// depth_zero set and saturated clear, else any clamp sets saturated.
// throughput is one beat per cycle while scr_o is not stalled. the pipe
// holds three multiply-accumulate stages, one prep stage, one stage per
// quotient bit of the restoring divider, and the output register.
// reset clears the pipeline valid bits; the store holds no defined value
// until loaded. a stalled receiver holds scr_o steady while empty stages
// behind it keep filling; pnt_i.ready drops only once the pipe is full.
module vertex_screen_projection import vsp_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  vsp_in_if.sink   pnt_i,
  vsp_out_if.source scr_o
);

  logic signed [COORD_WIDTH-1:0] point [4];
  logic signed [COORD_WIDTH-1:0] comp  [4];
  logic signed [COORD_WIDTH-1:0] depth;
  logic signed [COORD_WIDTH-1:0] res   [4];
  logic                          mac_valid, mac_ready, mac_sat;

  assign point[0] = pnt_i.point_x;
  assign point[1] = pnt_i.point_y;
  assign point[2] = pnt_i.point_z;
  assign point[3] = pnt_i.point_w;

  // matrix products and clamp
  vsp_mac #(
    .FRAC_BITS   (FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (pnt_i.valid),
    .in_ready_o   (pnt_i.ready),
    .operation_i  (pnt_i.operation),
    .coef_index_i (pnt_i.coef_index),
    .coef_value_i (pnt_i.coef_value),
    .point_i      (point),
    .out_valid_o  (mac_valid),
    .out_ready_i  (mac_ready),
    .comp_o       (comp),
    .depth_o      (depth),
    .sat_o        (mac_sat)
  );

  // perspective divide
  vsp_div #(
    .FRAC_BITS   (FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mac_valid),
    .in_ready_o  (mac_ready),
    .comp_i      (comp),
    .depth_i     (depth),
    .sat_i       (mac_sat),
    .out_valid_o (scr_o.valid),
    .out_ready_i (scr_o.ready),
    .res_o       (res),
    .zero_o      (scr_o.depth_zero),
    .sat_o       (scr_o.saturated)
  );

  assign scr_o.screen_x = res[0];
  assign scr_o.screen_y = res[1];
  assign scr_o.screen_z = res[2];
  assign scr_o.screen_w = res[3];

endmodule

>>> hw/rtl/vsp_mac.sv
module vsp_mac import vsp_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  op_e                           operation_i,
  input  logic [IDX_WIDTH-1:0]          coef_index_i,
  input  logic signed [COEF_WIDTH-1:0]  coef_value_i,
  input  logic signed [COORD_WIDTH-1:0] point_i [4],
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] comp_o [4],
  output logic signed [COORD_WIDTH-1:0] depth_o,
  output logic                          sat_o
);

  localparam int PW   = COEF_WIDTH + COORD_WIDTH;
  localparam int SW   = PW + 2;
  localparam int NROW = ROW_COUNT + 1;
  localparam logic [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [COEF_WIDTH-1:0] coef_q [COEF_COUNT];

  logic                  v1_q, v2_q, v3_q;
  logic                  r1, r2, r3;
  logic signed [PW-1:0]  prod_q [NROW][4];
  logic signed [SW-1:0]  sum_q  [NROW];
  logic signed [COORD_WIDTH-1:0] row_q [NROW];
  logic                  sat_q;
  logic                  acc_in;
  logic                  load;

  // ready chain, bubbles collapse
  assign r3 = !v3_q || out_ready_i;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o = r1;

  assign acc_in = in_valid_i && r1;
  assign load   = acc_in && (operation_i == OP_LOAD) &&
                  (coef_index_i < IDX_WIDTH'(COEF_COUNT));

  // coefficient store, loads land at acceptance
  always_ff @(posedge clk_i) begin
    if (load) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i && (operation_i == OP_XFORM);
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  // stage 1: twenty products against the current store
  always_ff @(posedge clk_i) begin
    if (r1) begin
      for (int r = 0; r < NROW; r++) begin
        for (int j = 0; j < 4; j++) begin
          prod_q[r][j] <= PW'(coef_q[r*4+j]) * PW'(point_i[j]);
        end
      end
    end
  end

  // stage 2: row sums
  always_ff @(posedge clk_i) begin
    if (r2) begin
      for (int r = 0; r < NROW; r++) begin
        sum_q[r] <= SW'(prod_q[r][0]) + SW'(prod_q[r][1]) +
                    SW'(prod_q[r][2]) + SW'(prod_q[r][3]);
      end
    end
  end

  // stage 3: floor shift and clamp
  logic signed [SW-1:0]          sh   [NROW];
  logic                          ok   [NROW];
  logic signed [COORD_WIDTH-1:0] cl   [NROW];
  logic                          sat_d;

  always_comb begin
    sat_d = 1'b0;
    for (int r = 0; r < NROW; r++) begin
      sh[r] = sum_q[r] >>> FRAC_BITS;
      ok[r] = (&sh[r][SW-1:COORD_WIDTH-1]) || !(|sh[r][SW-1:COORD_WIDTH-1]);
      cl[r] = ok[r] ? sh[r][COORD_WIDTH-1:0] : (sh[r][SW-1] ? MINV : MAXV);
      sat_d = sat_d || !ok[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (r3) begin
      row_q <= cl;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = v3_q;
  assign depth_o     = row_q[ROW_COUNT];
  assign sat_o       = sat_q;
  always_comb begin
    for (int i = 0; i < 4; i++) comp_o[i] = row_q[i];
  end

endmodule

>>> hw/rtl/vsp_div.sv
module vsp_div import vsp_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] comp_i [4],
  input  logic signed [COORD_WIDTH-1:0] depth_i,
  input  logic                          sat_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] res_o [4],
  output logic                          zero_o,
  output logic                          sat_o
);

  localparam int CW = COORD_WIDTH;
  localparam int N  = COORD_WIDTH + FRAC_BITS;
  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  // index 0 is the prep stage, 1..N the quotient bits, N+1 the output
  logic             v_q   [N+2];
  logic             rdy   [N+2];
  logic [CW-1:0]    ud_q  [N+1];
  vsp_flags_t       flg_q [N+1];
  logic [CW-1:0]    rem_q [N+1][4];
  logic [N-1:0]     quo_q [N+1][4];
  logic [N-1:0]     dvd_q [N+1][4];

  logic signed [CW-1:0] res_q [4];
  logic                 zero_q, sat_q;

  // ready chain
  assign rdy[N+1] = !v_q[N+1] || out_ready_i;
  for (genvar k = 0; k <= N; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N + 2; k++) v_q[k] <= 1'b0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < N + 2; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // prep: negate depth, split signs and magnitudes
  logic signed [CW-1:0] nd;
  logic                 nd_sat;
  logic [CW-1:0]        uc [4];
  vsp_flags_t           flg_d;

  always_comb begin
    nd_sat = (depth_i == MINV);
    nd     = nd_sat ? MAXV : -depth_i;
    flg_d.sat  = sat_i || nd_sat;
    flg_d.zero = (depth_i == '0);
    for (int i = 0; i < 4; i++) begin
      uc[i] = comp_i[i][CW-1] ? -comp_i[i] : comp_i[i];
      flg_d.neg[i] = comp_i[i][CW-1] ^ nd[CW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ud_q[0]  <= nd[CW-1] ? -nd : nd;
      flg_q[0] <= flg_d;
      for (int i = 0; i < 4; i++) begin
        rem_q[0][i] <= '0;
        quo_q[0][i] <= '0;
        dvd_q[0][i] <= {uc[i], {FRAC_BITS{1'b0}}};
      end
    end
  end

  // restoring divide, one quotient bit per stage in each lane
  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [CW:0] trial [4];
    logic        ge    [4];
    logic [CW:0] diff  [4];

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        trial[i] = {rem_q[k-1][i], dvd_q[k-1][i][N-1]};
        ge[i]    = trial[i] >= {1'b0, ud_q[k-1]};
        diff[i]  = trial[i] - {1'b0, ud_q[k-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        ud_q[k]  <= ud_q[k-1];
        flg_q[k] <= flg_q[k-1];
        for (int i = 0; i < 4; i++) begin
          rem_q[k][i] <= ge[i] ? diff[i][CW-1:0] : trial[i][CW-1:0];
          quo_q[k][i] <= {quo_q[k-1][i][N-2:0], ge[i]};
          dvd_q[k][i] <= {dvd_q[k-1][i][N-2:0], 1'b0};
        end
      end
    end
  end

  // output: clamp quotient, apply sign, zero depth override
  logic [N-1:0]         lim  [4];
  logic                 over [4];
  logic [N-1:0]         qc   [4];
  logic signed [CW-1:0] rv   [4];
  logic                 sat_any;

  always_comb begin
    sat_any = flg_q[N].sat;
    for (int i = 0; i < 4; i++) begin
      lim[i]  = flg_q[N].neg[i] ? N'({1'b0, MINV}) : N'(MAXV);
      over[i] = quo_q[N][i] > lim[i];
      qc[i]   = over[i] ? lim[i] : quo_q[N][i];
      rv[i]   = flg_q[N].neg[i] ? -qc[i][CW-1:0] : qc[i][CW-1:0];
      sat_any = sat_any || over[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[N+1]) begin
      zero_q <= flg_q[N].zero;
      sat_q  <= flg_q[N].zero ? 1'b0 : sat_any;
      for (int i = 0; i < 4; i++) begin
        res_q[i] <= flg_q[N].zero ? '0 : rv[i];
      end
    end
  end

  assign out_valid_o = v_q[N+1];
  assign zero_o      = zero_q;
  assign sat_o       = sat_q;
  always_comb begin
    for (int i = 0; i < 4; i++) res_o[i] = res_q[i];
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import vsp_pkg::*;

  localparam int FRAC  = 16;
  localparam int CW    = 32;
  localparam int LAT   = CW + FRAC + 5;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_BEATS = 650;

  typedef struct {
    logic [CW-1:0] x, y, z, w;
    logic          dz, sat;
  } screen_t;

  // scoreboard: coefficient store copy plus queue of predicted screen beats
  class projection_scoreboard;
    logic signed [31:0] coefs [COEF_COUNT];
    screen_t            pending_screens [$];
    bit                 clamped;
    int                 errors;

    function logic signed [CW-1:0] clamp_cw(logic signed [127:0] v);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< (CW - 1)) - 1;
      lo = -(128'sd1 <<< (CW - 1));
      if (v > hi) begin
        clamped = 1;
        return hi[CW-1:0];
      end
      if (v < lo) begin
        clamped = 1;
        return lo[CW-1:0];
      end
      return v[CW-1:0];
    endfunction

    function logic signed [CW-1:0] row_dot(int base, logic signed [CW-1:0] pt [4]);
      logic signed [127:0] acc;
      logic signed [127:0] c, p;
      acc = 0;
      for (int j = 0; j < 4; j++) begin
        c = coefs[base + j];
        p = pt[j];
        acc = acc + c * p;
      end
      return clamp_cw(acc >>> FRAC);
    endfunction

    function void note_beat(op_e op, logic [IDX_WIDTH-1:0] idx, logic signed [31:0] val,
                            logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                            logic signed [CW-1:0] pz, logic signed [CW-1:0] pw);
      logic signed [CW-1:0] pt [4];
      logic signed [CW-1:0] comp [4];
      logic signed [CW-1:0] dep;
      logic signed [127:0]  num, den;
      logic signed [CW-1:0] q [4];
      screen_t              s;
      if (op == OP_LOAD) begin
        if (idx < COEF_COUNT) coefs[idx] = val;
        return;
      end
      clamped = 0;
      pt[0] = px; pt[1] = py; pt[2] = pz; pt[3] = pw;
      for (int i = 0; i < ROW_COUNT; i++) comp[i] = row_dot(i * 4, pt);
      dep = row_dot(DEPTH_ROW, pt);
      if (dep == 0) begin
        s = '{x: '0, y: '0, z: '0, w: '0, dz: 1'b1, sat: 1'b0};
      end else begin
        // negate depth, most negative value clamps to the largest positive
        den = dep;
        den = -den;
        dep = clamp_cw(den);
        den = dep;
        for (int i = 0; i < 4; i++) begin
          num = comp[i];
          num = num <<< FRAC;
          q[i] = clamp_cw(num / den);
        end
        s = '{x: q[0], y: q[1], z: q[2], w: q[3], dz: 1'b0, sat: clamped};
      end
      pending_screens.push_back(s);
    endfunction

    function void check_screen(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                               logic [CW-1:0] w, logic dz, logic sat);
      screen_t e;
      if (pending_screens.size() == 0) begin
        $error("unexpected screen beat x=%h", x);
        errors++;
        return;
      end
      e = pending_screens.pop_front();
      if (x !== e.x) begin $error("screen_x exp %h got %h", e.x, x); errors++; end
      if (y !== e.y) begin $error("screen_y exp %h got %h", e.y, y); errors++; end
      if (z !== e.z) begin $error("screen_z exp %h got %h", e.z, z); errors++; end
      if (w !== e.w) begin $error("screen_w exp %h got %h", e.w, w); errors++; end
      if (dz !== e.dz) begin $error("depth_zero exp %b got %b", e.dz, dz); errors++; end
      if (sat !== e.sat) begin $error("saturated exp %b got %b", e.sat, sat); errors++; end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   quiet = 0;
  int   idle_cycles = 0;
  projection_scoreboard sb = new();

  vsp_in_if  #(.COORD_WIDTH(CW)) pnt ();
  vsp_out_if #(.COORD_WIDTH(CW)) scr ();

  vertex_screen_projection #(.FRAC_BITS(FRAC), .COORD_WIDTH(CW)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pnt_i  (pnt),
    .scr_o  (scr)
  );

  always #10 clk_i = ~clk_i;

  // sender side defaults, receiver starts not ready
  initial begin
    pnt.valid      = 1'b0;
    pnt.operation  = OP_LOAD;
    pnt.coef_index = '0;
    pnt.coef_value = '0;
    pnt.point_x    = '0;
    pnt.point_y    = '0;
    pnt.point_z    = '0;
    pnt.point_w    = '0;
    scr.ready      = 1'b0;
  end

  // receiver with random stall bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (scr.valid && scr.ready)
      sb.check_screen(scr.screen_x, scr.screen_y, scr.screen_z, scr.screen_w,
                      scr.depth_zero, scr.saturated);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      scr.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      scr.ready <= 1'b0;
    end else begin
      scr.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk_i) begin
    if ((pnt.valid && pnt.ready) || (scr.valid && scr.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_beat(op_e op, logic [IDX_WIDTH-1:0] idx, logic signed [31:0] val,
                           logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                           logic signed [CW-1:0] pz, logic signed [CW-1:0] pw);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      pnt.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    pnt.valid      <= 1'b1;
    pnt.operation  <= op;
    pnt.coef_index <= idx;
    pnt.coef_value <= val;
    pnt.point_x    <= px;
    pnt.point_y    <= py;
    pnt.point_z    <= pz;
    pnt.point_w    <= pw;
    @(posedge clk_i);
    while (!pnt.ready) @(posedge clk_i);
    sb.note_beat(op, idx, val, px, py, pz, pw);
  endtask

  task automatic load_coef(int idx, logic signed [31:0] val);
    send_beat(OP_LOAD, idx[IDX_WIDTH-1:0], val, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic project(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                         logic signed [CW-1:0] pz, logic signed [CW-1:0] pw);
    send_beat(OP_XFORM, IDX_WIDTH'($urandom), $urandom, px, py, pz, pw);
  endtask

  // mostly moderate Q16.16 values, sometimes extremes, zero or full range
  function automatic logic signed [31:0] rand_fixed();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity matrix, depth row picks -z so negated depth is z
    for (int i = 0; i < 16; i++) load_coef(i, (i % 5 == 0) ? ONE : 0);
    load_coef(16, 0); load_coef(17, 0); load_coef(18, -ONE); load_coef(19, 0);
    project(ONE, 2 * ONE, 4 * ONE, ONE);
    // zero depth
    project(ONE, -ONE, 0, ONE);
    // field extremes, saturating products
    project(MAXV, MAXV, MAXV, MAXV);
    project(MINV, MINV, MINV, MINV);
    project(MAXV, MINV, 1, -1);
    // out-of-range indexes are dropped
    load_coef(20, MINV);
    load_coef(31, MAXV);
    project(-3 * ONE, 5 * ONE, 2 * ONE, ONE);
    // depth clamps to most negative, negation saturates
    load_coef(16, MINV);
    project(MAXV, 0, ONE, ONE);
    load_coef(16, 0);

    // random mix of loads and transforms, mostly transforms
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n > RANDOM_BEATS - 120) quiet = 1;
      if ($urandom_range(0, 6) == 0)
        load_coef($urandom_range(0, 31), rand_fixed());
      else
        project(rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed());
    end
    pnt.valid <= 1'b0;

    // drain outstanding screen beats
    while (sb.pending_screens.size() != 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
